FILE: rtl/core/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC-16 byte update for the command frame
// builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned S_TDATA_W   = 40;

    localparam logic [CRC_W-1:0]  CRC_POLY       = 16'h8408;
    localparam logic [CRC_W-1:0]  CRC_INIT       = 16'h0000;
    localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd6;

    // Item kinds carried on the slave tuser bit
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Byte-emission sequencer, one-hot
    typedef enum logic [6:0] {
        PH_LEN   = 7'b0000001,
        PH_ENC   = 7'b0000010,
        PH_CMD   = 7'b0000100,
        PH_DATA  = 7'b0001000,
        PH_NONCE = 7'b0010000,
        PH_CRCH  = 7'b0100000,
        PH_CRCL  = 7'b1000000
    } t_phase;

    // Reflected CRC-16 update, one byte (LSB first)
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/command_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// command_frame_builder_crc16
// Builds length-prefixed command frames one byte per transaction and appends
// the nonce and a CRC-16 (reflected poly 0x8408, init 0), high byte first.
// ----------------------------------------------------------------------------
//  Channel  | Dir | tdata                                  | tuser      | tlast
//  ---------+-----+----------------------------------------+------------+----------
//  s_axis   | in  | cmd, enc type, payload len, nonce, data | 0 hdr/1 pl | -
//  m_axis   | out | frame byte                             | -          | frame end
//
//  A payload byte inside a frame emits one frame byte; a header emits three
//  bytes, and the closing item adds three more for nonce and CRC. A payload
//  item outside a frame is dropped with no output. The single output register
//  lets one frame byte leave per cycle while m_axis is ready. Reset is
//  synchronous, active low, and closes any open frame. Back-pressure on m_axis
//  holds the sequencer and, through it, s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_builder_crc16
    import cfb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave side
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] command_code, [15:8] encode_type, [23:16] payload_len,
    // [31:24] nonce, [39:32] data_byte
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] kind
    input  wire logic                 s_axis_tuser,
    // master side
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] frame_byte
    output logic [BYTE_W-1:0]         m_axis_tdata,
    output logic                      m_axis_tlast
);

    // Input (job) register
    logic              r_job_valid, n_job_valid;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_cmd, r_enc, r_plen, r_nonce_in, r_data;

    // Frame state
    logic              r_in_frame, n_in_frame;
    logic [BYTE_W-1:0] r_bytes_left, n_bytes_left;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_held_nonce, n_held_nonce;

    // Output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              emit_ok, emit, done, accept;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;

    always_comb begin
        emit_ok      = !r_out_valid || m_axis_tready;
        emit         = 1'b0;
        done         = 1'b0;
        emit_byte    = '0;
        emit_last    = 1'b0;
        n_phase      = r_phase;
        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_held_nonce = r_held_nonce;

        if (r_job_valid) begin
            case (r_phase)
                PH_LEN: begin
                    emit_byte = r_plen + FRAME_OVERHEAD;
                    if (emit_ok) begin
                        emit         = 1'b1;
                        n_crc        = crc_byte(CRC_INIT, emit_byte);
                        n_held_nonce = r_nonce_in;
                        n_bytes_left = r_plen;
                        n_in_frame   = 1'b1;
                        n_phase      = PH_ENC;
                    end
                end
                PH_ENC: begin
                    emit_byte = r_enc;
                    if (emit_ok) begin
                        emit    = 1'b1;
                        n_crc   = crc_byte(r_crc, emit_byte);
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    emit_byte = r_cmd;
                    if (emit_ok) begin
                        emit  = 1'b1;
                        n_crc = crc_byte(r_crc, emit_byte);
                        if (r_bytes_left == '0) begin
                            n_phase = PH_NONCE;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                PH_DATA: begin
                    emit_byte = r_data;
                    if (!r_in_frame) begin
                        // payload outside a frame: drop it
                        done = 1'b1;
                    end else if (emit_ok) begin
                        emit         = 1'b1;
                        n_crc        = crc_byte(r_crc, emit_byte);
                        n_bytes_left = r_bytes_left - 8'd1;
                        if (n_bytes_left == '0) begin
                            n_phase = PH_NONCE;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                PH_NONCE: begin
                    emit_byte = r_held_nonce;
                    if (emit_ok) begin
                        emit    = 1'b1;
                        n_crc   = crc_byte(r_crc, emit_byte);
                        n_phase = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    emit_byte = r_crc[15:8];
                    if (emit_ok) begin
                        emit    = 1'b1;
                        n_phase = PH_CRCL;
                    end
                end
                PH_CRCL: begin
                    emit_byte = r_crc[7:0];
                    emit_last = 1'b1;
                    if (emit_ok) begin
                        emit         = 1'b1;
                        n_in_frame   = 1'b0;
                        n_bytes_left = '0;
                        done         = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end

        s_axis_tready = !r_job_valid || done;
        accept        = s_axis_tvalid && s_axis_tready;

        if (accept) begin
            n_job_valid = 1'b1;
            n_phase     = (s_axis_tuser == KIND_PAYLOAD) ? PH_DATA : PH_LEN;
        end else if (done) begin
            n_job_valid = 1'b0;
        end else begin
            n_job_valid = r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid  <= 1'b0;
            r_phase      <= PH_LEN;
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
            r_crc        <= CRC_INIT;
            r_held_nonce <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_job_valid  <= n_job_valid;
            r_phase      <= n_phase;
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_held_nonce <= n_held_nonce;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job data and output byte registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= s_axis_tdata[7:0];
            r_enc      <= s_axis_tdata[15:8];
            r_plen     <= s_axis_tdata[23:16];
            r_nonce_in <= s_axis_tdata[31:24];
            r_data     <= s_axis_tdata[39:32];
        end
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_loads_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_job_valid)
        else $error("accepted transaction did not load the job register");

    a_tail_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && (r_phase == PH_NONCE || r_phase == PH_CRCH ||
                        r_phase == PH_CRCL) |-> r_in_frame)
        else $error("frame tail sequenced with no open frame");

    a_last_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !r_in_frame)
        else $error("frame end shown while frame still open");

    a_crcl_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && r_phase == PH_CRCL && emit_ok |=> m_axis_tvalid && m_axis_tlast)
        else $error("low CRC byte not marked as frame end");

    a_no_emit_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_job_valid && m_axis_tready |=> !m_axis_tvalid)
        else $error("output produced with no job in flight");

endmodule

`default_nettype wire
